### rtl/bciv_pkg.sv
package bciv_pkg;

   // Depth counter width follows the 6-bit nesting field
   localparam int NEST_W = 6;

   // Container stack entry codes
   localparam logic [1:0] ENT_NONE    = 2'd0;
   localparam logic [1:0] ENT_LIST    = 2'd1;
   localparam logic [1:0] ENT_DICT_K  = 2'd2;
   localparam logic [1:0] ENT_DICT_V  = 2'd3;

   // Result status codes
   localparam logic [1:0] ST_PROGRESS = 2'd0;
   localparam logic [1:0] ST_COMPLETE = 2'd1;
   localparam logic [1:0] ST_ERROR    = 2'd2;
   localparam logic [1:0] ST_IGNORED  = 2'd3;

   // Token kind codes
   localparam logic [2:0] TK_NONE     = 3'd0;
   localparam logic [2:0] TK_INTEGER  = 3'd1;
   localparam logic [2:0] TK_STRING   = 3'd2;
   localparam logic [2:0] TK_LIST     = 3'd3;
   localparam logic [2:0] TK_DICT     = 3'd4;
   localparam logic [2:0] TK_END      = 3'd5;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       first;
      logic       last;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [31:0]       byte_total;
      logic [NEST_W-1:0] nesting;
      logic [2:0]        token_kind;
   } rsp_type;

   // Stack control from the parser to the stack memory
   typedef struct packed {
      logic              push;
      logic [NEST_W-1:0] depth;
      logic [NEST_W-1:0] depth_next;
      logic [1:0]        entry;
   } stack_cmd_type;

endpackage

### rtl/bciv_stack.sv
module bciv_stack #(
   parameter int DEPTH = 32
) (
   input  logic                   clock,
   input  bciv_pkg::stack_cmd_type cmd,
   output logic [1:0]             below
);
   import bciv_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [1:0]    stack_mem [DEPTH];
   logic [1:0]    below_ff;
   logic [AW-1:0] wr_addr;
   logic [AW-1:0] rd_addr;
   logic          wr_en;

   // The top entry lives in the parser; push spills the old top to memory
   assign wr_en   = cmd.push && (cmd.depth != '0);
   assign wr_addr = AW'(int'(cmd.depth) - 1);
   // Prefetch the entry just below the next top
   assign rd_addr = AW'(int'(cmd.depth_next) - 2);

   // Write spilled entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_mem[wr_addr] <= cmd.entry;
      end
   end

   // Registered read, forward a same-cycle spill
   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr == rd_addr)) begin
         below_ff <= cmd.entry;
      end else begin
         below_ff <= stack_mem[rd_addr];
      end
   end

   assign below = below_ff;

endmodule

### rtl/bencode_item_validator.sv
// Result: registered and shown in the cycle after its byte transfer.
// Throughput: one byte per cycle unless a held response stalls req_ready; the
// stack top is held in a register and the entry below it is prefetched from the
// stack memory every cycle, so a pop never waits on the memory read.
// Reset: synchronous; parser returns to expect-item, counters clear, max_depth
// returns to 32. Stack memory is not cleared; entries are written on push.
module bencode_item_validator #(
   parameter int DEPTH    = 32,
   parameter int LEN_BITS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  bciv_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output bciv_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [5:0]        csr_data
);
   import bciv_pkg::*;

   // Parser modes
   localparam logic [3:0] M_EXPECT     = 4'd0;
   localparam logic [3:0] M_INT_START  = 4'd1;
   localparam logic [3:0] M_INT_NEG    = 4'd2;
   localparam logic [3:0] M_INT_ZERO   = 4'd3;
   localparam logic [3:0] M_INT_DIGITS = 4'd4;
   localparam logic [3:0] M_STR_ZERO   = 4'd5;
   localparam logic [3:0] M_STR_LEN    = 4'd6;
   localparam logic [3:0] M_STR_BODY   = 4'd7;
   localparam logic [3:0] M_DONE       = 4'd8;
   localparam logic [3:0] M_ERROR      = 4'd9;

   // Characters
   localparam logic [7:0] CH_I     = 8'h69;
   localparam logic [7:0] CH_L     = 8'h6C;
   localparam logic [7:0] CH_D     = 8'h64;
   localparam logic [7:0] CH_E     = 8'h65;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_COLON = 8'h3A;

   localparam int LW = LEN_BITS + 4;

   logic [3:0]          mode_ff, mode_in;
   logic [NEST_W-1:0]   depth_ff, depth_in;
   logic [1:0]          top_ff, top_in;
   logic [LEN_BITS-1:0] rem_ff, rem_in;
   logic [LEN_BITS-1:0] count_ff, count_in;
   logic [5:0]          max_depth_ff;
   logic                rsp_valid_ff;
   rsp_type             rsp_data_ff;

   logic                accept;
   logic [1:0]          below;
   stack_cmd_type       stack_cmd;

   logic [3:0]          mode_cur, mode_c;
   logic [NEST_W-1:0]   depth_cur, depth_c;
   logic [LEN_BITS-1:0] rem_cur, rem_c;
   logic [LEN_BITS-1:0] count_cur, count_c;
   logic [1:0]          top_cur, top_c;
   logic [NEST_W-1:0]   limit;
   logic [7:0]          b;
   logic                is_dig;
   logic [3:0]          dig;
   logic [LW-1:0]       rem_ext, rem_mul;
   logic                push_c, elem_end, err;
   logic [1:0]          status_c;
   logic [2:0]          kind_c;
   rsp_type             rsp_c;

   assign accept    = req_valid && req_ready;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Effective state after an optional restart on the first byte
   assign mode_cur  = req_data.first ? M_EXPECT : mode_ff;
   assign depth_cur = req_data.first ? '0 : depth_ff;
   assign rem_cur   = req_data.first ? '0 : rem_ff;
   assign count_cur = req_data.first ? '0 : count_ff;
   assign top_cur   = (depth_cur == '0) ? ENT_NONE : top_ff;

   assign b      = req_data.data_byte;
   assign is_dig = (b >= CH_ZERO) && (b <= CH_NINE);
   assign dig    = 4'(b - CH_ZERO);

   // Next string length: rem * 10 + digit, overflow shows in the top bits
   assign rem_ext = LW'(rem_cur);
   assign rem_mul = (rem_ext << 3) + (rem_ext << 1) + LW'(dig);

   // Nesting limit is the smaller of the register and the stack size
   always_comb begin
      if (int'(max_depth_ff) < DEPTH) begin
         limit = max_depth_ff;
      end else begin
         limit = NEST_W'(DEPTH);
      end
   end

   // Parse one byte
   always_comb begin
      mode_c   = mode_cur;
      depth_c  = depth_cur;
      rem_c    = rem_cur;
      count_c  = count_cur;
      top_c    = top_ff;
      push_c   = 1'b0;
      elem_end = 1'b0;
      err      = 1'b0;
      status_c = ST_PROGRESS;
      kind_c   = TK_NONE;

      if (mode_cur == M_DONE) begin
         status_c = ST_IGNORED;
      end else if (mode_cur == M_ERROR) begin
         status_c = ST_ERROR;
      end else if (&count_cur) begin
         err = 1'b1;
      end else begin
         count_c = count_cur + 1'b1;
         unique case (mode_cur)
            M_EXPECT: begin
               priority if (b == CH_E) begin
                  if (top_cur != ENT_LIST && top_cur != ENT_DICT_K) begin
                     err = 1'b1;
                  end else begin
                     depth_c  = depth_cur - 1'b1;
                     top_c    = below;
                     kind_c   = TK_END;
                     elem_end = 1'b1;
                  end
               end else if (top_cur == ENT_DICT_K) begin
                  if (!is_dig) begin
                     err = 1'b1;
                  end else begin
                     kind_c = TK_STRING;
                     rem_c  = LEN_BITS'(dig);
                     mode_c = (b == CH_ZERO) ? M_STR_ZERO : M_STR_LEN;
                  end
               end else if (b == CH_I) begin
                  kind_c = TK_INTEGER;
                  mode_c = M_INT_START;
               end else if (b == CH_L || b == CH_D) begin
                  if (depth_cur >= limit) begin
                     err = 1'b1;
                  end else begin
                     push_c  = 1'b1;
                     top_c   = (b == CH_L) ? ENT_LIST : ENT_DICT_K;
                     depth_c = depth_cur + 1'b1;
                     kind_c  = (b == CH_L) ? TK_LIST : TK_DICT;
                  end
               end else if (is_dig) begin
                  kind_c = TK_STRING;
                  rem_c  = LEN_BITS'(dig);
                  mode_c = (b == CH_ZERO) ? M_STR_ZERO : M_STR_LEN;
               end else begin
                  err = 1'b1;
               end
            end
            M_INT_START: begin
               priority if (b == CH_MINUS) begin
                  mode_c = M_INT_NEG;
               end else if (b == CH_ZERO) begin
                  mode_c = M_INT_ZERO;
               end else if (is_dig) begin
                  mode_c = M_INT_DIGITS;
               end else begin
                  err = 1'b1;
               end
            end
            M_INT_NEG: begin
               if (!is_dig || b == CH_ZERO) begin
                  err = 1'b1;
               end else begin
                  mode_c = M_INT_DIGITS;
               end
            end
            M_INT_ZERO: begin
               if (b != CH_E) begin
                  err = 1'b1;
               end else begin
                  elem_end = 1'b1;
               end
            end
            M_INT_DIGITS: begin
               if (!is_dig) begin
                  if (b != CH_E) begin
                     err = 1'b1;
                  end else begin
                     elem_end = 1'b1;
                  end
               end
            end
            M_STR_ZERO: begin
               if (b != CH_COLON) begin
                  err = 1'b1;
               end else begin
                  elem_end = 1'b1;
               end
            end
            M_STR_LEN: begin
               priority if (is_dig) begin
                  if (|rem_mul[LW-1:LEN_BITS]) begin
                     err = 1'b1;
                  end else begin
                     rem_c = rem_mul[LEN_BITS-1:0];
                  end
               end else if (b != CH_COLON) begin
                  err = 1'b1;
               end else begin
                  mode_c = M_STR_BODY;
               end
            end
            M_STR_BODY: begin
               if (rem_cur != '0) begin
                  rem_c = rem_cur - 1'b1;
               end
               if (rem_c == '0) begin
                  elem_end = 1'b1;
               end
            end
            default: begin
               err = 1'b1;
            end
         endcase

         // Close an element: finish the item or flip the dict slot
         if (elem_end) begin
            if (depth_c == '0) begin
               mode_c   = M_DONE;
               status_c = ST_COMPLETE;
            end else begin
               mode_c = M_EXPECT;
               if (top_c == ENT_DICT_K) begin
                  top_c = ENT_DICT_V;
               end else if (top_c == ENT_DICT_V) begin
                  top_c = ENT_DICT_K;
               end
            end
         end

         // Truncated buffer
         if (!err && status_c == ST_PROGRESS && req_data.last) begin
            err = 1'b1;
         end
      end

      // Error is sticky
      if (err) begin
         mode_c   = M_ERROR;
         status_c = ST_ERROR;
         kind_c   = TK_NONE;
      end
   end

   // Hold state unless a byte transfers
   assign mode_in  = accept ? mode_c : mode_ff;
   assign depth_in = accept ? depth_c : depth_ff;
   assign top_in   = accept ? top_c : top_ff;
   assign rem_in   = accept ? rem_c : rem_ff;
   assign count_in = accept ? count_c : count_ff;

   assign rsp_c.status     = status_c;
   assign rsp_c.byte_total = 32'(count_c);
   assign rsp_c.nesting    = depth_c;
   assign rsp_c.token_kind = kind_c;

   // Spill the old top on push; prefetch below the next top
   assign stack_cmd.push       = accept && push_c;
   assign stack_cmd.depth      = depth_cur;
   assign stack_cmd.depth_next = depth_in;
   assign stack_cmd.entry      = top_ff;

   bciv_stack #(
      .DEPTH(DEPTH)
   ) u_stack (
      .clock(clock),
      .cmd  (stack_cmd),
      .below(below)
   );

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= M_EXPECT;
         depth_ff     <= '0;
         rem_ff       <= '0;
         count_ff     <= '0;
         max_depth_ff <= 6'd32;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         depth_ff     <= depth_in;
         rem_ff       <= rem_in;
         count_ff     <= count_in;
         rsp_valid_ff <= accept || (rsp_valid_ff && !rsp_ready);
         if (csr_valid && csr_ready) begin
            max_depth_ff <= csr_data;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      top_ff <= top_in;
      if (accept) begin
         rsp_data_ff <= rsp_c;
      end
   end

endmodule
